// ----- hdl/klq_pkg.sv -----
// shared types, constants and the percent lookup for the knob level qualifier
`default_nettype none

package klq_pkg;

   // fixed field widths
   localparam int unsigned REQ_SAMPLE_W = 16;
   localparam int unsigned REQ_TDATA_W  = 16;
   localparam int unsigned RSP_TDATA_W  = 16;
   localparam int unsigned LEVEL_W      = 3;
   localparam int unsigned PCT_W        = 7;
   localparam int unsigned HYST_W       = 9;
   localparam int unsigned JIT_W        = 12;
   localparam int unsigned CNT_W        = 8;
   localparam int unsigned CSR_IDX_W    = 2;
   localparam int unsigned CSR_DATA_W   = 12;

   // converter and band setup
   localparam int unsigned ADC_MAX_DEF  = 4095;
   localparam int unsigned LEVELS       = 5;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_HYST_MARGIN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_JITTER  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CONFIRM_CNT = 2'd2;

   // register reset values
   localparam logic [HYST_W-1:0] HYST_RST    = 9'd32;
   localparam logic [JIT_W-1:0]  JIT_RST     = 12'd128;
   localparam logic [CNT_W-1:0]  CONFIRM_RST = 8'd3;

   localparam logic [CNT_W-1:0]  CNT_SAT     = 8'd255;

   // brightness table
   localparam logic [PCT_W-1:0] PCT_LVL0 = 7'd3;
   localparam logic [PCT_W-1:0] PCT_LVL1 = 7'd12;
   localparam logic [PCT_W-1:0] PCT_LVL2 = 7'd30;
   localparam logic [PCT_W-1:0] PCT_LVL3 = 7'd60;
   localparam logic [PCT_W-1:0] PCT_LVL4 = 7'd100;

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic [PCT_W-1:0]   percent;
      logic               changed;
   } klq_result_type;

   function automatic logic [PCT_W-1:0] level_percent(input logic [LEVEL_W-1:0] lvl);
      logic [PCT_W-1:0] pct;
      case (lvl)
         3'd0:    pct = PCT_LVL0;
         3'd1:    pct = PCT_LVL1;
         3'd2:    pct = PCT_LVL2;
         3'd3:    pct = PCT_LVL3;
         3'd4:    pct = PCT_LVL4;
         default: pct = PCT_LVL4;
      endcase
      return pct;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/klq_propose.sv -----
// band proposal with hysteresis: parallel compares against the band boundaries
`default_nettype none

module klq_propose #(
   parameter int unsigned ADC_MAX = klq_pkg::ADC_MAX_DEF,
   parameter int unsigned SW      = $clog2(ADC_MAX + 1)
) (
   input  wire logic [SW-1:0]                 sample,
   input  wire logic [klq_pkg::LEVEL_W-1:0]   committed,
   input  wire logic [klq_pkg::HYST_W-1:0]    margin,
   output      logic [klq_pkg::LEVEL_W-1:0]   proposal
);
   import klq_pkg::*;

   localparam int unsigned BAND_W = (ADC_MAX + 1) / LEVELS;
   localparam int unsigned SUM_W  = ((SW > HYST_W) ? SW : HYST_W) + 1;

   logic [SUM_W-1:0]   s_ext;
   logic [SUM_W-1:0]   m_ext;
   logic [SUM_W-1:0]   s_plus_m;
   logic [LEVEL_W-1:0] up_cnt;
   logic [LEVEL_W-1:0] dn_cnt;

   // boundaries rise with k, so the hits form a prefix and counting them gives the band
   always_comb begin
      logic [SUM_W-1:0] top;
      s_ext    = SUM_W'(sample);
      m_ext    = SUM_W'(margin);
      s_plus_m = s_ext + m_ext;
      up_cnt   = '0;
      dn_cnt   = '0;
      for (int k = 0; k < LEVELS - 1; k++) begin
         top = SUM_W'((k + 1) * BAND_W);
         if (s_ext > top + m_ext) up_cnt = up_cnt + LEVEL_W'(1);
         if (s_plus_m >= top)     dn_cnt = dn_cnt + LEVEL_W'(1);
      end
      if (committed < up_cnt) begin
         proposal = up_cnt;
      end else if (committed > dn_cnt) begin
         proposal = dn_cnt;
      end else begin
         proposal = committed;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/klq_track.sv -----
// debounce state: candidate, anchor and confirm counter, plus the result build
`default_nettype none

module klq_track #(
   parameter int unsigned ADC_MAX = klq_pkg::ADC_MAX_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              fire,
   input  wire logic [klq_pkg::REQ_SAMPLE_W-1:0]  raw_sample,
   input  wire logic [klq_pkg::HYST_W-1:0]        hyst_margin,
   input  wire logic [klq_pkg::JIT_W-1:0]         max_jitter,
   input  wire logic [klq_pkg::CNT_W-1:0]         confirm_count,
   output      klq_pkg::klq_result_type           result
);
   import klq_pkg::*;

   localparam int unsigned SW   = $clog2(ADC_MAX + 1);
   localparam int unsigned CMPW = (SW > JIT_W) ? SW : JIT_W;
   localparam logic [REQ_SAMPLE_W-1:0] MAX_IN = REQ_SAMPLE_W'(ADC_MAX);

   logic [LEVEL_W-1:0] committed_ff, committed_in;
   logic [LEVEL_W-1:0] candidate_ff, candidate_in;
   logic [SW-1:0]      anchor_ff, anchor_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   logic [SW-1:0]      sample;
   logic [SW-1:0]      anchor_gap;
   logic [CNT_W-1:0]   count_inc;
   logic [LEVEL_W-1:0] proposal;
   logic               changed;

   assign sample = (raw_sample > MAX_IN) ? SW'(MAX_IN) : SW'(raw_sample);
   assign anchor_gap = (sample > anchor_ff) ? (sample - anchor_ff) : (anchor_ff - sample);
   assign count_inc = (count_ff == CNT_SAT) ? CNT_SAT : (count_ff + CNT_W'(1));

   klq_propose #(
      .ADC_MAX (ADC_MAX),
      .SW      (SW)
   ) u_propose (
      .sample    (sample),
      .committed (committed_ff),
      .margin    (hyst_margin),
      .proposal  (proposal)
   );

   always_comb begin
      committed_in = committed_ff;
      candidate_in = candidate_ff;
      anchor_in    = anchor_ff;
      count_in     = count_ff;
      changed      = 1'b0;
      if (proposal == committed_ff) begin
         candidate_in = committed_ff;
         count_in     = '0;
      end else if (proposal != candidate_ff || CMPW'(anchor_gap) > CMPW'(max_jitter)) begin
         // new candidacy opens at this sample
         candidate_in = proposal;
         anchor_in    = sample;
         count_in     = CNT_W'(1);
      end else if (count_inc >= confirm_count) begin
         committed_in = candidate_ff;
         count_in     = '0;
         changed      = 1'b1;
      end else begin
         count_in     = count_inc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         committed_ff <= '0;
         candidate_ff <= '0;
         anchor_ff    <= '0;
         count_ff     <= '0;
      end else if (fire) begin
         committed_ff <= committed_in;
         candidate_ff <= candidate_in;
         anchor_ff    <= anchor_in;
         count_ff     <= count_in;
      end
   end

   assign result.level   = committed_in;
   assign result.percent = level_percent(committed_in);
   assign result.changed = changed;

endmodule

`default_nettype wire

// ----- hdl/knob_level_qualifier.sv -----
// top level of the knob level qualifier: channels, control registers, pipeline
`default_nettype none

// channel   | dir | handshake               | payload
// req_      | in  | req_tvalid/req_tready   | tdata[15:0] adc_sample
// rsp_      | out | rsp_tvalid/rsp_tready   | tdata[2:0] level, [9:3] percent, [10] changed
// csr_      | in  | csr_valid/csr_ready     | csr_index, csr_wdata
//
// one sample per cycle sustained while rsp_tready is high; rsp_tvalid is registered
// the decision and state update for a sample happen as it moves from the input
// register to the result register, so the next sample sees the new state at once
// reset loads the register defaults and clears level, candidate, anchor and counter
// a stalled result holds in the result register while one more sample waits behind it
// csr_ready is always high; writes are expected only while the block is idle

module knob_level_qualifier #(
   parameter int unsigned ADC_MAX = klq_pkg::ADC_MAX_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // input samples
   input  wire logic                              req_tvalid,
   output      logic                              req_tready,
   input  wire logic [klq_pkg::REQ_TDATA_W-1:0]   req_tdata,   // [15:0] adc_sample
   // results
   output      logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   output      logic [klq_pkg::RSP_TDATA_W-1:0]   rsp_tdata,   // [2:0] level, [9:3] percent,
                                                               // [10] changed, rest zero
   // register writes
   input  wire logic                              csr_valid,
   output      logic                              csr_ready,
   input  wire logic [klq_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [klq_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import klq_pkg::*;

   localparam int unsigned PAD_W = RSP_TDATA_W - LEVEL_W - PCT_W - 1;

   // control registers
   logic [HYST_W-1:0]       hyst_ff;
   logic [JIT_W-1:0]        jit_ff;
   logic [CNT_W-1:0]        confirm_ff;

   // input stage
   logic                    in_vld_ff, in_vld_in;
   logic [REQ_SAMPLE_W-1:0] in_data_ff;

   // result stage
   logic                    rsp_vld_ff, rsp_vld_in;
   klq_result_type          rsp_data_ff;

   klq_result_type          result;
   logic                    advance;
   logic                    fire;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         hyst_ff    <= HYST_RST;
         jit_ff     <= JIT_RST;
         confirm_ff <= CONFIRM_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_HYST_MARGIN: hyst_ff    <= csr_wdata[HYST_W-1:0];
            CSR_MAX_JITTER:  jit_ff     <= csr_wdata[JIT_W-1:0];
            CSR_CONFIRM_CNT: confirm_ff <= csr_wdata[CNT_W-1:0];
            default: ;  // writes past the register list are dropped
         endcase
      end
   end

   // result register frees when empty or when its transaction completes
   assign advance    = !rsp_vld_ff || rsp_tready;
   assign fire       = in_vld_ff && advance;
   assign req_tready = !in_vld_ff || advance;

   assign in_vld_in  = req_tready ? req_tvalid : in_vld_ff;
   assign rsp_vld_in = advance ? in_vld_ff : rsp_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_data_ff <= req_tdata[REQ_SAMPLE_W-1:0];
      end
      if (fire) begin
         rsp_data_ff <= result;
      end
   end

   klq_track #(
      .ADC_MAX (ADC_MAX)
   ) u_track (
      .clock         (clock),
      .reset         (reset),
      .fire          (fire),
      .raw_sample    (in_data_ff),
      .hyst_margin   (hyst_ff),
      .max_jitter    (jit_ff),
      .confirm_count (confirm_ff),
      .result        (result)
   );

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {PAD_W'(0), rsp_data_ff.changed, rsp_data_ff.percent,
                        rsp_data_ff.level};

endmodule

`default_nettype wire
